>>> design/grid_line_of_sight_macros.svh
// Assertion macros for the grid line-of-sight block.
`ifndef GRID_LINE_OF_SIGHT_MACROS_SVH
`define GRID_LINE_OF_SIGHT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, checked out of reset
`define GLOS_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("grid_line_of_sight assertion failed");
// next-cycle implication, checked out of reset
`define GLOS_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("grid_line_of_sight assertion failed");
`else
`define GLOS_ASSERT_IMP(name, ante, cons)
`define GLOS_ASSERT_NEXT(name, ante, cons)
`endif
`endif

>>> design/glos_pkg.sv
// Shared types and constants for the grid line-of-sight block.
package glos_pkg;

    localparam int MAP_WIDTH_DEF  = 256;
    localparam int MAP_HEIGHT_DEF = 256;
    localparam int COORD_W        = 8;
    // |e| stays below 2*255*255, so 18 bits signed hold it
    localparam int E_W            = 18;

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    typedef struct packed {
        logic               mode;
        logic [COORD_W-1:0] cell_x;
        logic [COORD_W-1:0] cell_y;
        logic               wall_bit;
        logic [COORD_W-1:0] observer_x;
        logic [COORD_W-1:0] observer_y;
    } cmd_item_t;

    typedef struct packed {
        logic visible;
    } res_item_t;

    // map access strobes from the walker to the map store
    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic wr_bit;
    } map_cmd_t;

endpackage

>>> design/glos_if.sv
// Valid/ready channel interfaces for command and result items.
interface glos_cmd_if;
    import glos_pkg::*;

    logic      valid;
    logic      ready;
    cmd_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface glos_res_if;
    import glos_pkg::*;

    logic      valid;
    logic      ready;
    res_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> design/glos_map.sv
// One-bit wall map store with a clearing sweep after reset.
module glos_map #(
    parameter int ADDR_W = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  glos_pkg::map_cmd_t cmd,
    input  logic [ADDR_W-1:0]  addr,
    output logic               rdata,
    output logic               busy
);
    import glos_pkg::*;

    localparam int DEPTH = 2 ** ADDR_W;

    logic              mem [DEPTH];
    logic [ADDR_W-1:0] clr_reg;
    logic [ADDR_W-1:0] clr_next;
    logic              clearing_reg;
    logic              clearing_next;
    logic              rdata_reg;
    logic              we;
    logic [ADDR_W-1:0] wa;
    logic              wd;

    always_comb
    begin
        clr_next      = clr_reg;
        clearing_next = clearing_reg;
        if (clearing_reg)
        begin
            clr_next = clr_reg + ADDR_W'(1);
            if (clr_reg == {ADDR_W{1'b1}})
            begin
                clearing_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg      <= '0;
            clearing_reg <= 1'b1;
        end
        else
        begin
            clr_reg      <= clr_next;
            clearing_reg <= clearing_next;
        end
    end

    // the sweep owns the write port until it is done
    assign we = clearing_reg | cmd.wr_en;
    assign wa = clearing_reg ? clr_reg : addr;
    assign wd = clearing_reg ? 1'b0 : cmd.wr_bit;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        if (cmd.rd_en)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;
    assign busy  = clearing_reg;

endmodule

>>> design/grid_line_of_sight.sv
// Top level: wall map writes and 4-connected line-of-sight walks.
//
//  channel  dir  payload                                               handshake
//  cmd      in   mode, cell_x, cell_y, wall_bit, observer_x, observer_y  valid/ready
//  res      out  visible (one per query, none per write)                valid/ready
//
// A write item is written to the map in the cycle it is accepted. A query walks at most
// |dx|+|dy|+1 cells, set by the single map read port: one cell per cycle while not held.
// After reset the map is swept clear, all 2**ADDR_W cells (65536 by default), with
// cmd.ready low. A walk pauses while the previous result is still unread.
module grid_line_of_sight #(
    parameter int MAP_WIDTH  = glos_pkg::MAP_WIDTH_DEF,
    parameter int MAP_HEIGHT = glos_pkg::MAP_HEIGHT_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    glos_cmd_if.sink        cmd,
    glos_res_if.source      res
);
    import glos_pkg::*;

`include "grid_line_of_sight_macros.svh"

    localparam int EFF_W  = (MAP_WIDTH < 256) ? MAP_WIDTH : 256;
    localparam int EFF_H  = (MAP_HEIGHT < 256) ? MAP_HEIGHT : 256;
    localparam int XB     = $clog2(EFF_W);
    localparam int YB     = $clog2(EFF_H);
    localparam int ADDR_W = XB + YB;
    localparam logic [COORD_W:0] X_LIM = (COORD_W + 1)'(EFF_W);
    localparam logic [COORD_W:0] Y_LIM = (COORD_W + 1)'(EFF_H);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_WALK = 1'b1;

    logic                      state_reg, state_next;
    logic [COORD_W-1:0]        px_reg, px_next;
    logic [COORD_W-1:0]        py_reg, py_next;
    logic [COORD_W-1:0]        ox_reg, ox_next;
    logic [COORD_W-1:0]        oy_reg, oy_next;
    logic signed [COORD_W:0]   dx_reg, dx_next;
    logic signed [COORD_W:0]   dy_reg, dy_next;
    logic signed [E_W-1:0]     e_reg, e_next;
    logic                      pend_reg, pend_next;
    logic                      pend_last_reg, pend_last_next;
    logic                      pend_in_reg, pend_in_next;
    logic                      res_valid_reg, res_valid_next;
    logic                      vis_reg, vis_next;

    map_cmd_t                  map_cmd;
    logic [ADDR_W-1:0]         map_addr;
    logic                      map_rdata;
    logic                      map_busy;

    logic                      accept;
    logic                      go;
    logic                      wall;
    logic                      finish;
    logic                      cur_in;
    logic                      cmd_in;
    logic signed [E_W-1:0]     dx_e, dy_e;
    logic                      dx_pos, dx_neg, dy_pos, dy_neg, e_pos;
    logic [COORD_W-1:0]        sx, sy;
    logic signed [E_W-1:0]     se;

    glos_map #(
        .ADDR_W (ADDR_W)
    ) u_map (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (map_cmd),
        .addr  (map_addr),
        .rdata (map_rdata),
        .busy  (map_busy)
    );

    assign cmd.ready     = (state_reg == ST_IDLE) && !map_busy;
    assign accept        = cmd.valid && cmd.ready;
    assign res.valid     = res_valid_reg;
    assign res.data.visible = vis_reg;

    // walk holds while an older result sits unread
    assign go     = !(res_valid_reg && !res.ready);
    assign wall   = map_rdata & pend_in_reg;
    assign finish = pend_reg && (wall || pend_last_reg);

    assign cur_in = ({1'b0, px_reg} < X_LIM) && ({1'b0, py_reg} < Y_LIM);
    assign cmd_in = ({1'b0, cmd.data.cell_x} < X_LIM) && ({1'b0, cmd.data.cell_y} < Y_LIM);

    // one 4-connected step; e tracks (x-ox)*dy - (y-oy)*dx, zero at the target
    assign dx_e   = E_W'(dx_reg);
    assign dy_e   = E_W'(dy_reg);
    assign dx_neg = dx_reg[COORD_W];
    assign dy_neg = dy_reg[COORD_W];
    assign dx_pos = !dx_neg && (dx_reg != '0);
    assign dy_pos = !dy_neg && (dy_reg != '0);
    assign e_pos  = !e_reg[E_W-1] && (e_reg != '0);

    always_comb
    begin
        sx = px_reg;
        sy = py_reg;
        se = e_reg;
        if (e_pos)
        begin
            if (!dx_neg && dy_pos)
            begin
                sy = py_reg + COORD_W'(1);
                se = e_reg - dx_e;
            end
            else if (dx_pos && !dy_pos)
            begin
                sx = px_reg + COORD_W'(1);
                se = e_reg + dy_e;
            end
            else if (dx_neg && !dy_neg)
            begin
                sx = px_reg - COORD_W'(1);
                se = e_reg - dy_e;
            end
            else if (!dx_pos && dy_neg)
            begin
                sy = py_reg - COORD_W'(1);
                se = e_reg + dx_e;
            end
        end
        else
        begin
            if (dx_pos && !dy_neg)
            begin
                sx = px_reg + COORD_W'(1);
                se = e_reg + dy_e;
            end
            else if (!dx_neg && dy_neg)
            begin
                sy = py_reg - COORD_W'(1);
                se = e_reg + dx_e;
            end
            else if (!dx_pos && dy_pos)
            begin
                sy = py_reg + COORD_W'(1);
                se = e_reg - dx_e;
            end
            else if (dx_neg && !dy_pos)
            begin
                sx = px_reg - COORD_W'(1);
                se = e_reg - dy_e;
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        px_next        = px_reg;
        py_next        = py_reg;
        ox_next        = ox_reg;
        oy_next        = oy_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        e_next         = e_reg;
        pend_next      = pend_reg;
        pend_last_next = pend_last_reg;
        pend_in_next   = pend_in_reg;
        res_valid_next = res_valid_reg;
        vis_next       = vis_reg;
        map_cmd        = '0;
        map_addr       = {py_reg[YB-1:0], px_reg[XB-1:0]};

        if (res_valid_reg && res.ready)
        begin
            res_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (cmd.data.mode == MODE_WRITE)
                    begin
                        map_cmd.wr_en  = cmd_in;
                        map_cmd.wr_bit = cmd.data.wall_bit;
                        map_addr = {cmd.data.cell_y[YB-1:0], cmd.data.cell_x[XB-1:0]};
                    end
                    else
                    begin
                        px_next    = cmd.data.cell_x;
                        py_next    = cmd.data.cell_y;
                        ox_next    = cmd.data.observer_x;
                        oy_next    = cmd.data.observer_y;
                        dx_next    = $signed({1'b0, cmd.data.observer_x})
                                   - $signed({1'b0, cmd.data.cell_x});
                        dy_next    = $signed({1'b0, cmd.data.observer_y})
                                   - $signed({1'b0, cmd.data.cell_y});
                        e_next     = '0;
                        pend_next  = 1'b0;
                        state_next = ST_WALK;
                    end
                end
            end
            ST_WALK:
            begin
                if (go)
                begin
                    if (finish)
                    begin
                        res_valid_next = 1'b1;
                        vis_next       = !wall;
                        pend_next      = 1'b0;
                        state_next     = ST_IDLE;
                    end
                    else
                    begin
                        // read this cell while the step to the next one is taken
                        map_cmd.rd_en  = cur_in;
                        pend_next      = 1'b1;
                        pend_in_next   = cur_in;
                        pend_last_next = (px_reg == ox_reg) && (py_reg == oy_reg);
                        px_next        = sx;
                        py_next        = sy;
                        e_next         = se;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pend_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pend_reg      <= pend_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        px_reg        <= px_next;
        py_reg        <= py_next;
        ox_reg        <= ox_next;
        oy_reg        <= oy_next;
        dx_reg        <= dx_next;
        dy_reg        <= dy_next;
        e_reg         <= e_next;
        pend_last_reg <= pend_last_next;
        pend_in_reg   <= pend_in_next;
        vis_reg       <= vis_next;
    end

    `GLOS_ASSERT_NEXT(a_query_starts_walk, accept && (cmd.data.mode == MODE_QUERY), (state_reg == ST_WALK) && (e_reg == '0) && !pend_reg)
    `GLOS_ASSERT_IMP(a_result_from_walk, $rose(res_valid_reg), $past(state_reg) == ST_WALK)
    `GLOS_ASSERT_NEXT(a_walk_holds, (state_reg == ST_WALK) && res_valid_reg && !res.ready, $stable(px_reg) && $stable(py_reg) && $stable(e_reg))
    `GLOS_ASSERT_IMP(a_no_accept_in_clear, map_busy, !accept)

endmodule

>>> dv/grid_line_of_sight_tb.sv
// Self-checking testbench for the grid line-of-sight block: map writes and walked queries.
module grid_line_of_sight_tb;
    import glos_pkg::*;

    localparam int GRID_SIZE        = 256;
    localparam int WALK_GUARD       = 1024;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int SETTLE_CYCLES    = 32;
    localparam int RUN_LIMIT        = 16_000_000;

    logic clk;
    logic rst_n;

    glos_cmd_if cmd_ch();
    glos_res_if res_ch();

    // wall map copy, indexed [y][x]
    bit wall_model [0:GRID_SIZE-1][0:GRID_SIZE-1];
    bit visible_expect_q [$];
    int error_count = 0;
    bit no_idle = 1'b0;
    int hold_request = 0;

    grid_line_of_sight uut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .res   (res_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #RUN_LIMIT;
        $display("Regression FAIL");
        $finish;
    end

    function automatic int idle_draw();
        return no_idle ? 0 : $urandom_range(0, 6);
    endfunction

    // walk from target to observer, stop at the first wall
    function automatic bit walk_visible(int tx, int ty, int ox, int oy);
        int x;
        int y;
        int dx;
        int dy;
        int e;
        int steps;
        bit vis;
        x = tx;
        y = ty;
        dx = ox - tx;
        dy = oy - ty;
        steps = 0;
        vis = 1'b1;
        while (1)
        begin
            if (x >= 0 && y >= 0 && x < GRID_SIZE && y < GRID_SIZE && wall_model[y][x])
            begin
                vis = 1'b0;
                break;
            end
            if ((x == ox && y == oy) || steps >= WALK_GUARD)
                break;
            e = (x - ox) * dy - (y - oy) * dx;
            if (e > 0)
            begin
                if (dx >= 0 && dy > 0) y++;
                else if (dx > 0 && dy <= 0) x++;
                else if (dx < 0 && dy >= 0) x--;
                else if (dx <= 0 && dy < 0) y--;
            end
            else
            begin
                if (dx > 0 && dy >= 0) x++;
                else if (dx >= 0 && dy < 0) y--;
                else if (dx <= 0 && dy > 0) y++;
                else if (dx < 0 && dy <= 0) x--;
            end
            steps++;
        end
        return vis;
    endfunction

    // append one expected visible bit at the tail of the queue
    task automatic expect_visible(input bit vis);
        visible_expect_q = {visible_expect_q, vis};
    endtask

    // valid is left high after an item unless a gap follows; release_cmd drops it
    task automatic send_cmd(input cmd_item_t item);
        int gap;
        cmd_ch.data  <= item;
        cmd_ch.valid <= 1'b1;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
        if (item.mode == MODE_WRITE)
            wall_model[item.cell_y][item.cell_x] = item.wall_bit;
        else
            expect_visible(walk_visible(item.cell_x, item.cell_y,
                                        item.observer_x, item.observer_y));
        gap = idle_draw();
        if (gap > 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic release_cmd();
        cmd_ch.valid <= 1'b0;
    endtask

    task automatic wait_drained();
        do
            @(posedge clk);
        while (visible_expect_q.size() != 0);
    endtask

    task automatic send_write(input int x, input int y, input bit wall);
        cmd_item_t item;
        item.mode       = MODE_WRITE;
        item.cell_x     = COORD_W'(x);
        item.cell_y     = COORD_W'(y);
        item.wall_bit   = wall;
        item.observer_x = COORD_W'($urandom_range(0, 255));
        item.observer_y = COORD_W'($urandom_range(0, 255));
        send_cmd(item);
    endtask

    task automatic send_query(input int tx, input int ty, input int ox, input int oy);
        cmd_item_t item;
        item.mode       = MODE_QUERY;
        item.cell_x     = COORD_W'(tx);
        item.cell_y     = COORD_W'(ty);
        item.wall_bit   = 1'($urandom_range(0, 1));
        item.observer_x = COORD_W'(ox);
        item.observer_y = COORD_W'(oy);
        send_cmd(item);
    endtask

    // mostly local traffic in a window so walls actually land on the walked lines
    task automatic send_random_item(input int bx, input int by, input int span);
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 5)
            send_query($urandom_range(0, 255), $urandom_range(0, 255),
                       $urandom_range(0, 255), $urandom_range(0, 255));
        else if (pick < 50)
            send_write(bx + $urandom_range(0, span - 1), by + $urandom_range(0, span - 1),
                       $urandom_range(0, 9) < 7);
        else
            send_query(bx + $urandom_range(0, span - 1), by + $urandom_range(0, span - 1),
                       bx + $urandom_range(0, span - 1), by + $urandom_range(0, span - 1));
    endtask

    task automatic run_random_windows(input int n_items);
        int span;
        int bx;
        int by;
        for (int i = 0; i < n_items; i++)
        begin
            if (i % 50 == 0)
            begin
                span = $urandom_range(4, 40);
                bx = $urandom_range(0, GRID_SIZE - span);
                by = $urandom_range(0, GRID_SIZE - span);
            end
            send_random_item(bx, by, span);
        end
    endtask

    task automatic test_directed();
        // single cell and the four long diagonals on an empty map
        send_query(0, 0, 0, 0);
        send_query(0, 0, 255, 255);
        send_query(255, 255, 0, 0);
        send_query(255, 0, 0, 255);
        send_query(0, 255, 255, 0);
        // wall at either end of the walk
        send_write(255, 255, 1'b1);
        send_query(255, 255, 255, 255);
        send_query(0, 0, 255, 255);
        send_query(255, 255, 0, 0);
        send_write(255, 255, 1'b0);
        send_query(255, 255, 0, 0);
        // straight walks in all four directions across one wall
        send_write(10, 20, 1'b1);
        send_query(10, 0, 10, 40);
        send_query(10, 40, 10, 0);
        send_query(0, 20, 40, 20);
        send_query(40, 20, 0, 20);
        send_query(10, 20, 10, 20);
        send_write(0, 0, 1'b1);
        send_query(0, 0, 0, 0);
        send_write(0, 0, 1'b0);
        send_query(3, 7, 30, 2);
        send_query(30, 2, 3, 7);
    endtask

    task automatic test_random_walks();
        run_random_windows(900);
    endtask

    task automatic test_back_to_back();
        no_idle = 1'b1;
        run_random_windows(150);
        no_idle = 1'b0;
    endtask

    task automatic test_result_backpressure();
        hold_request = LONG_HOLD_CYCLES;
        run_random_windows(40);
    endtask

    task automatic test_drain_then_resume();
        release_cmd();
        wait_drained();
        run_random_windows(50);
    endtask

    // result side: random ready gaps, long hold on request, check each item
    initial
    begin
        int stall;
        bit want;
        res_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_request > 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (hold_request) @(posedge clk);
                hold_request = 0;
            end
            else
            begin
                stall = idle_draw();
                if (stall > 0)
                begin
                    res_ch.ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
            end
            res_ch.ready <= 1'b1;
            @(posedge clk);
            while (!res_ch.valid)
                @(posedge clk);
            if (visible_expect_q.size() == 0)
            begin
                error_count++;
                $display("%0t: result with none expected, expected none, actual visible=%0b",
                         $time, res_ch.data.visible);
            end
            else
            begin
                want = visible_expect_q.pop_front();
                if (res_ch.data.visible !== want)
                begin
                    error_count++;
                    $display("%0t: visible mismatch, expected %0b, actual %0b",
                             $time, want, res_ch.data.visible);
                end
            end
        end
    end

    initial
    begin
        rst_n        <= 1'b0;
        cmd_ch.valid <= 1'b0;
        cmd_ch.data  <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_random_walks();
        test_back_to_back();
        test_result_backpressure();
        test_drain_then_resume();

        release_cmd();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

>>> grid_line_of_sight.f
+incdir+design
design/glos_pkg.sv
design/glos_if.sv
design/glos_map.sv
design/grid_line_of_sight.sv
dv/grid_line_of_sight_tb.sv
